>>> sv/zof_pkg.sv
// Shared types and constants for the z-score outlier flagger.
// Every other module of the block but zof_ram imports this package.
package zof_pkg;

    localparam int SAMPLE_W = 32;
    localparam int THR_W    = 16;
    localparam int CNT_W    = 7;    // holds a count up to 64
    localparam int SUM_W    = 38;   // signed sum of up to 64 samples
    localparam int TOT_W    = 70;   // sum of up to 64 squared deviations
    localparam int VAR_W    = 64;
    localparam int SD_W     = 32;
    localparam int ROW_W    = 6;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd768;
    localparam logic [CNT_W-1:0] MIN_SAMPLES     = 7'd3;

    typedef enum logic [1:0] {
        ST_REPORT = 2'd0,
        ST_FEW    = 2'd1,
        ST_FLAT   = 2'd2,
        ST_OVER   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]           row_index;
        logic                       is_outlier;
        status_t                    status;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [30:0]                std_dev;
        logic                       last_result;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_run;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic div_mean;
        logic div_var;
        logic mean_cap;
        logic abs_cap;
        logic sq_cap;
        logic acc_en;
        logic sqrt_start;
        logic sd_cap;
        logic thr_cap;
        logic out_rep;
        logic out_stat;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ovf;
        logic lt3;
        logic div_done;
        logic sqrt_done;
        logic sd_zero;
        logic idx_last;
        logic slot_free;
    } sts_t;

endpackage

>>> sv/zof_ram.sv
// Generic simple dual-port RAM with registered read data.
// No package dependencies.
module zof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/zof_divider.sv
// Bit-serial restoring divider: unsigned 70-bit dividend by a 7-bit count.
// Depends on zof_pkg for widths.
module zof_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [zof_pkg::TOT_W-1:0] dividend,
    input  logic [zof_pkg::CNT_W-1:0] divisor,
    output logic [zof_pkg::TOT_W-1:0] quotient,
    output logic [zof_pkg::CNT_W-1:0] remainder,
    output logic                      done
);
    import zof_pkg::*;

    logic [TOT_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [CNT_W:0]   trial;

    // one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[TOT_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = CNT_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[TOT_W-2:0], 1'b1};
        end else begin
            rem_next = trial[CNT_W-1:0];
            quo_next = {quo_reg[TOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;
endmodule

>>> sv/zof_sqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on zof_pkg for widths.
module zof_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [zof_pkg::VAR_W-1:0] radicand,
    output logic [zof_pkg::SD_W-1:0]  root,
    output logic                      done
);
    import zof_pkg::*;

    logic [VAR_W-1:0] v_reg, res_reg, bit_reg;
    logic [VAR_W-1:0] trial;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // digit-by-digit: test res + bit against the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= VAR_W'(1) << (VAR_W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[SD_W-1:0];
    assign done = done_reg;
endmodule

>>> sv/zof_datapath.sv
// Datapath: sample store, running sums, mean/variance/root units, flag compare,
// threshold register and result register. Depends on zof_pkg, zof_ram,
// zof_divider and zof_sqrt.
module zof_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  zof_pkg::cmd_t             cmd,
    output zof_pkg::sts_t             sts,
    input  zof_pkg::in_t              s_data,
    input  logic                      cfg_valid,
    input  logic [zof_pkg::THR_W-1:0] cfg_threshold,
    output logic                      m_valid,
    input  logic                      m_ready,
    output zof_pkg::out_t             m_data
);
    import zof_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [TOT_W-1:0]        total_reg;
    logic                    ovf_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [THR_W-1:0]        thr_reg;
    logic signed [31:0]      mean_reg;
    logic [31:0]             ad_reg;
    logic [63:0]             sq_reg;
    logic [SD_W-1:0]         sd_reg;
    logic [47:0]             thr_prod_reg;
    logic                    m_valid_reg;
    out_t                    out_reg;

    logic                    full;
    logic                    store;
    logic [31:0]             rdata;
    logic [TOT_W-1:0]        div_quo;
    logic [CNT_W-1:0]        div_rem;
    logic                    div_done;
    logic [TOT_W-1:0]        div_in;
    logic [SD_W-1:0]         root;
    logic                    sqrt_done;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [32:0]             mean_mag;
    logic signed [31:0]      mean_next;
    logic signed [32:0]      dev;
    logic [31:0]             ad;
    logic                    flag;
    logic [30:0]             sd_out;
    status_t                 stat_code;

    assign full  = (count_reg == CNT_W'(MAX_SAMPLES));
    assign store = cmd.load && !full;

    zof_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk  (aclk),
        .we    (store),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_data.sample),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // |sum| for the mean, total of squares for the variance
    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_in  = cmd.div_mean ? TOT_W'(sum_mag) : total_reg;

    zof_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_mean || cmd.div_var),
        .dividend  (div_in),
        .divisor   (count_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    zof_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (div_quo[VAR_W-1:0]),
        .root     (root),
        .done     (sqrt_done)
    );

    // floor division: round toward minus infinity for a negative sum
    always_comb begin
        if (sum_neg) begin
            mean_mag  = 33'(div_quo[31:0]) + 33'(div_rem != '0);
            mean_next = 32'(-mean_mag);
        end else begin
            mean_mag  = 33'(div_quo[31:0]);
            mean_next = mean_mag[31:0];
        end
    end

    // deviation of the sample on the read port
    assign dev    = 33'(signed'(rdata)) - 33'(mean_reg);
    assign ad     = dev[32] ? 32'(-dev) : dev[31:0];
    assign flag   = ({ad, 8'd0} > thr_prod_reg[39:0]) || 1'b0
                    ? (48'({ad, 8'd0}) > thr_prod_reg) : 1'b0;
    assign sd_out = sd_reg[31] ? 31'h7fff_ffff : sd_reg[30:0];

    always_comb begin
        if (ovf_reg) begin
            stat_code = ST_OVER;
        end else if (count_reg < MIN_SAMPLES) begin
            stat_code = ST_FEW;
        end else begin
            stat_code = ST_FLAT;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            thr_reg     <= THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_threshold;
            end
            if (cmd.clear_run) begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.load) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(s_data.sample);
                end
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.out_rep || cmd.out_stat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.div_mean) begin
            total_reg <= '0;
        end else if (cmd.acc_en) begin
            total_reg <= total_reg + TOT_W'(sq_reg);
        end
        if (cmd.mean_cap) begin
            mean_reg <= mean_next;
        end
        if (cmd.abs_cap) begin
            ad_reg <= ad;
        end
        if (cmd.sq_cap) begin
            sq_reg <= ad_reg * ad_reg;
        end
        if (cmd.sd_cap) begin
            sd_reg <= root;
        end
        if (cmd.thr_cap) begin
            thr_prod_reg <= thr_reg * sd_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_rep) begin
            out_reg.row_index   <= ROW_W'(idx_reg);
            out_reg.is_outlier  <= flag;
            out_reg.status      <= ST_REPORT;
            out_reg.mean_value  <= mean_reg;
            out_reg.std_dev     <= sd_out;
            out_reg.last_result <= sts.idx_last;
        end else if (cmd.out_stat) begin
            out_reg.row_index   <= '0;
            out_reg.is_outlier  <= 1'b0;
            out_reg.status      <= stat_code;
            out_reg.mean_value  <= (stat_code == ST_FLAT) ? mean_reg : '0;
            out_reg.std_dev     <= '0;
            out_reg.last_result <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign sts.ovf       = ovf_reg;
    assign sts.lt3       = (count_reg < MIN_SAMPLES);
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.sd_zero   = (sd_reg == '0);
    assign sts.idx_last  = (CNT_W'(idx_reg) + 1'b1 == count_reg);
    assign sts.slot_free = !m_valid_reg || m_ready;
endmodule

>>> sv/zof_ctrl.sv
// Controller state machine: load phase, mean, variance, root, report passes and status result.
// Depends on zof_pkg for the command and status structs.
module zof_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          last_sample,
    input  zof_pkg::sts_t sts,
    output zof_pkg::cmd_t cmd
);
    import zof_pkg::*;

    typedef enum logic [14:0] {
        S_LOAD = 15'b000000000000001,
        S_CHK  = 15'b000000000000010,
        S_MEAN = 15'b000000000000100,
        S_VRD  = 15'b000000000001000,
        S_VABS = 15'b000000000010000,
        S_VSQ  = 15'b000000000100000,
        S_VACC = 15'b000000001000000,
        S_VDST = 15'b000000010000000,
        S_VDIV = 15'b000000100000000,
        S_SQRT = 15'b000001000000000,
        S_SDC  = 15'b000010000000000,
        S_THR  = 15'b000100000000000,
        S_FRD  = 15'b001000000000000,
        S_FOUT = 15'b010000000000000,
        S_STAT = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (last_sample) begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (sts.ovf || sts.lt3) begin
                    state_next = S_STAT;
                end else begin
                    cmd.div_mean = 1'b1;
                    state_next   = S_MEAN;
                end
            end
            S_MEAN: begin
                if (sts.div_done) begin
                    cmd.mean_cap = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_VRD;
                end
            end
            S_VRD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_VABS;
            end
            S_VABS: begin
                cmd.abs_cap = 1'b1;
                state_next  = S_VSQ;
            end
            S_VSQ: begin
                cmd.sq_cap = 1'b1;
                state_next = S_VACC;
            end
            S_VACC: begin
                cmd.acc_en = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_VDST;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_VRD;
                end
            end
            S_VDST: begin
                cmd.div_var = 1'b1;
                state_next  = S_VDIV;
            end
            S_VDIV: begin
                if (sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sts.sqrt_done) begin
                    cmd.sd_cap = 1'b1;
                    state_next = S_SDC;
                end
            end
            S_SDC: begin
                cmd.thr_cap = 1'b1;
                state_next  = S_THR;
            end
            S_THR: begin
                if (sts.sd_zero) begin
                    state_next = S_STAT;
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FRD;
                end
            end
            S_FRD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_FOUT;
            end
            S_FOUT: begin
                if (sts.slot_free) begin
                    cmd.out_rep = 1'b1;
                    if (sts.idx_last) begin
                        cmd.clear_run = 1'b1;
                        state_next    = S_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_FRD;
                    end
                end
            end
            S_STAT: begin
                if (sts.slot_free) begin
                    cmd.out_stat  = 1'b1;
                    cmd.clear_run = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> sv/zscore_outlier_flagger_top.sv
// Z-score outlier flagger: samples load at one transaction per cycle while
// s_ready is high. The transaction marked last_sample starts a closing burst:
// the mean in the shared bit-serial divider, a squared-deviation pass over
// the stored samples, the variance in the same divider (70 quotient bits
// each), the square-root unit and a report pass, which output backpressure
// can stall. A short or overfull column goes straight to its status result;
// a flat one reaches it after the square root. Input is not taken during the
// burst. It gives one report result per stored sample, or one status result
// for a short, flat or overfull column; a finished result may wait in the
// output register while the next column loads. threshold is written on its
// own channel (cfg_ready is always high); the user must write it only between
// runs, as the block itself does not enforce this. Depends on zof_pkg,
// zof_ctrl and zof_datapath.
module zscore_outlier_flagger_top #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  zof_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output zof_pkg::out_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [zof_pkg::THR_W-1:0] cfg_threshold
);
    import zof_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    zof_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .last_sample (s_data.last_sample),
        .sts         (sts),
        .cmd         (cmd)
    );

    zof_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_data        (s_data),
        .cfg_valid     (cfg_valid),
        .cfg_threshold (cfg_threshold),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );
endmodule

>>> bench/testbench.sv
// Self-checking testbench for zscore_outlier_flagger_top: a directed table,
// then random columns, checked by a column statistics model or typed rows.
// Depends on zof_pkg and the zscore_outlier_flagger_top RTL.
module testbench;
    import zof_pkg::*;

    localparam int MAX_ROWS   = 64;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [31:0] smp;
        bit          last;
        bit          typed;
        out_t        exp;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_threshold;

    // column model state
    logic [31:0] col_store[$];
    longint      col_sum;
    bit          col_ovf;
    logic [15:0] thr_model;

    out_t        pending_results[$];
    stim_row_t   dir_tab[$];
    int          mismatches;
    int          cycle_cnt = 0;
    int          rand_items;
    bit          calm;
    bit          hold_req;

    zscore_outlier_flagger_top #(.MAX_SAMPLES(MAX_ROWS)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_threshold (cfg_threshold)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic out_t status_result(input status_t st, input logic [31:0] mean);
        out_t r;
        r = '0;
        r.status      = st;
        r.mean_value  = mean;
        r.last_result = 1'b1;
        return r;
    endfunction

    // Column statistics: accumulate a sample, and on the last one produce
    // either the per-row report or a single status transaction.
    task automatic column_stats(input logic [31:0] smp, input bit last, output out_t res[$]);
        longint          n, mean, d;
        longint unsigned ad, quo, rem, sd;
        out_t            r;
        res = {};
        if (col_store.size() < MAX_ROWS) begin
            col_store = {col_store, smp};
            col_sum += longint'($signed(smp));
        end else begin
            col_ovf = 1'b1;
        end
        if (!last) return;
        n = col_store.size();
        if (col_ovf) begin
            res = {res, status_result(ST_OVER, '0)};
        end else if (n < 3) begin
            res = {res, status_result(ST_FEW, '0)};
        end else begin
            mean = col_sum / n;
            if (col_sum % n != 0 && col_sum < 0) mean--;
            quo = 0;
            rem = 0;
            foreach (col_store[i]) begin
                d   = longint'($signed(col_store[i])) - mean;
                ad  = d < 0 ? -d : d;
                quo += (ad * ad) / n;
                rem += (ad * ad) % n;
                if (rem >= n) begin
                    rem -= n;
                    quo++;
                end
            end
            sd = int_sqrt(quo);
            if (sd == 0) begin
                res = {res, status_result(ST_FLAT, mean[31:0])};
            end else begin
                foreach (col_store[i]) begin
                    d  = longint'($signed(col_store[i])) - mean;
                    ad = d < 0 ? -d : d;
                    r.row_index   = i[5:0];
                    r.is_outlier  = (ad * 256) > (longint'(thr_model) * sd);
                    r.status      = ST_REPORT;
                    r.mean_value  = mean[31:0];
                    r.std_dev     = sd > 64'h7FFFFFFF ? 31'h7FFFFFFF : sd[30:0];
                    r.last_result = (i == n - 1);
                    res = {res, r};
                end
            end
        end
        col_store = {};
        col_sum   = 0;
        col_ovf   = 1'b0;
    endtask

    // Offer one sample; called at a rising edge, returns at the accepting edge.
    task automatic send_sample(input logic [31:0] smp, input bit last,
                               input bit typed = 0, input out_t exp = '0);
        int   gap;
        out_t res[$];
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_data.sample      <= smp;
        s_data.last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        column_stats(smp, last, res);
        if (typed) pending_results = {pending_results, exp};
        else pending_results = {pending_results, res};
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        cfg_valid     <= 1'b1;
        cfg_threshold <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_model = v;
    endtask

    // One random column: kind 0 wide, 1 clustered with spikes, 2 flat.
    task automatic random_column(input int n, input int kind);
        logic [31:0] base, smp;
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: smp = $urandom;
                1: begin
                    smp = base + $urandom_range(0, 32'h0002_0000);
                    if ($urandom_range(0, 7) == 0) smp = smp + ($urandom | 32'h0100_0000);
                end
                default: smp = base;
            endcase
            send_sample(smp, i == n - 1);
            rand_items++;
        end
    endtask

    // Result checking and output stalls.
    initial begin : result_side
        int stall;
        int long_hold;
        out_t exp;
        stall     = 0;
        long_hold = 0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", m_data);
                end else begin
                    exp = pending_results.pop_front();
                    if (m_data.row_index !== exp.row_index ||
                        m_data.is_outlier !== exp.is_outlier ||
                        m_data.status !== exp.status ||
                        m_data.mean_value !== exp.mean_value ||
                        m_data.std_dev !== exp.std_dev ||
                        m_data.last_result !== exp.last_result) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", exp, m_data);
                    end
                end
                stall = calm ? 0 : $urandom_range(0, 3);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                long_hold = 1000;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus_side
        logic [15:0] thr_list[4];
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_threshold = '0;
        col_sum       = 0;
        col_ovf       = 1'b0;
        thr_model     = THRESHOLD_RESET;
        mismatches    = 0;
        rand_items    = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed columns at the reset threshold
        dir_tab = '{
            '{32'h7FFF_FFFF, 1, 1, status_result(ST_FEW, '0)},
            '{32'h8000_0000, 0, 0, '0},
            '{32'h7FFF_FFFF, 1, 1, status_result(ST_FEW, '0)},
            '{32'h0001_0000, 0, 0, '0},
            '{32'h0001_0000, 0, 0, '0},
            '{32'h0001_0000, 1, 1, status_result(ST_FLAT, 32'h0001_0000)},
            '{32'h8000_0000, 0, 0, '0},
            '{32'h8000_0000, 0, 0, '0},
            '{32'h8000_0001, 1, 0, '0},
            '{32'h8000_0000, 0, 0, '0},
            '{32'h7FFF_FFFF, 0, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'hFFFF_FFFF, 1, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'h0000_0000, 0, 0, '0},
            '{32'h0064_0000, 1, 0, '0}
        };
        foreach (dir_tab[i])
            send_sample(dir_tab[i].smp, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].exp);
        drain();

        // threshold extremes, then two mid values
        thr_list = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0080};
        foreach (thr_list[t]) begin
            write_threshold(thr_list[t]);
            random_column(4, 1);
            random_column(3, 0);
            drain();
        end

        // with the receiver held off: an overfull column, then two more columns
        write_threshold(THRESHOLD_RESET);
        hold_req = 1'b1;
        random_column(66, 1);
        random_column(6, 0);
        random_column(4, 0);
        drain();

        // random phases
        while (rand_items < 110) begin
            write_threshold(16'($urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(128, 1024)));
            calm = ($urandom_range(0, 3) == 0);
            repeat (2) begin
                case ($urandom_range(0, 9))
                    0:       random_column($urandom_range(1, 2), 0);
                    1:       random_column($urandom_range(3, 6), 2);
                    2, 3:    random_column($urandom_range(3, 12), 0);
                    default: random_column($urandom_range(3, 12), 1);
                endcase
            end
            drain();
        end
        calm = 1'b0;

        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
